@@ src/tgfl_pkg.sv @@
`timescale 1ns / 1ps

package tgfl_pkg;

    // Fixed widths of the transaction fields and configuration registers.
    localparam int POS_W      = 24;
    localparam int DIST_W     = POS_W + 1;
    localparam int CNT_W      = 9;
    localparam int CELL_W     = 16;
    localparam int LDA_W      = 18;
    localparam int FIELD_W    = 24;
    localparam int COMP_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // The count registers hold up to 511, but a cell index is kept in eight bits, enough for 256 points per axis.
    localparam int IDX_BITS = 8;
    localparam int SPAN_W   = IDX_BITS + CELL_W;
    localparam int T1_W     = IDX_BITS + CNT_W;
    localparam int SX_W     = 2 * CNT_W - 1;
    localparam int FLAT_W   = T1_W + CNT_W;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [COMP_W-1:0] COMP_NONE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_Z   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 3'd6;

    typedef struct packed {
        logic                    command;
        logic [COMP_W-1:0]       component;
        logic [LDA_W-1:0]        load_address;
        logic signed [POS_W-1:0] load_value;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0] field_value;
        logic               inside_res;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_LOCATE,
        S_ADDR_A,
        S_ADDR_B,
        S_READ,
        S_READ_LAST,
        S_MUL,
        S_ADD
    } t_state;

endpackage

@@ src/tgfl_ram.sv @@
`timescale 1ns / 1ps

module tgfl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/tgfl_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, two quotient bits per cycle. Produces floor(dist * 2^FRAC_BITS / cell)
// split into the cell index and the fraction. Valid while dist < cell * 2^IDX_W.
module tgfl_div
    import tgfl_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    localparam int STEPS = (IDX_BITS + FRAC_BITS + 1) / 2,
    localparam int QBP   = 2 * STEPS,
    localparam int IDX_W = QBP - FRAC_BITS,
    localparam int CNT_BITS = $clog2(STEPS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [POS_W-1:0]     i_dist,
    input  logic [CELL_W-1:0]    i_cell,
    output logic                 o_done,
    output logic [IDX_W-1:0]     o_index,
    output logic [FRAC_BITS-1:0] o_frac
);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [CELL_W-1:0]   r_cell;
    logic [CELL_W-1:0]   r_rem;
    logic [QBP-1:0]      r_bits;

    logic [CELL_W:0]   t1;
    logic [CELL_W:0]   t2;
    logic              ge1;
    logic              ge2;
    logic [CELL_W-1:0] rem1;
    logic [CELL_W-1:0] rem2;

    always_comb begin
        t1   = {r_rem, r_bits[QBP-1]};
        ge1  = t1 >= {1'b0, r_cell};
        rem1 = ge1 ? CELL_W'(t1 - {1'b0, r_cell}) : t1[CELL_W-1:0];
        t2   = {rem1, r_bits[QBP-2]};
        ge2  = t2 >= {1'b0, r_cell};
        rem2 = ge2 ? CELL_W'(t2 - {1'b0, r_cell}) : t2[CELL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_BITS'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + CNT_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cell <= i_cell;
            r_rem  <= CELL_W'(i_dist >> IDX_W);
            r_bits <= {i_dist[IDX_W-1:0], {FRAC_BITS{1'b0}}};
        end else if (r_busy) begin
            r_rem  <= rem2;
            r_bits <= {r_bits[QBP-3:0], ge1, ge2};
        end
    end

    assign o_done  = r_done;
    assign o_index = r_bits[QBP-1:FRAC_BITS];
    assign o_frac  = r_bits[FRAC_BITS-1:0];

endmodule

@@ src/trilinear_grid_field_lookup_core.sv @@
// Trilinear field lookup on a regular 3D grid, three component tables in one memory.
// Input channel: a transaction is taken at a rising edge with i_start high and o_busy low.
// A load transaction writes one table word (none for component three) in that same cycle
// and gives no result; the block stays free, so loads can follow on every cycle. A query
// transaction returns one result on o_result, marked by o_valid for exactly one cycle; the
// receiver cannot stall it and must take it in that cycle.
// A query runs through three parallel dividers (two quotient bits per cycle), a cell
// location state, the address states S_ADDR_A and S_ADDR_B, eight corner reads from the
// single port memory, and seven blends on one shared multiplier, each a multiply state
// then an add state. A position outside the grid or component three answers after
// location, with no reads or blends. o_busy drops in the cycle the result shows, so the
// next transaction may start then. One query occupies the block at a time.
// Configuration registers are written through i_cfg_we / i_cfg_index / i_cfg_data while
// the block is idle; the user must keep to that, as the block itself does not enforce it.
// Reset restores the register defaults and idles the controller; the table memory is not
// cleared, and each word must be loaded before a query reads it.
`timescale 1ns / 1ps

module trilinear_grid_field_lookup_core
    import tgfl_pkg::*;
#(
    parameter int ADDR_BITS  = 18,
    parameter int VALUE_BITS = 24,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  t_in_item              i_item,
    output logic                  o_valid,
    output t_out_item             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int RAM_AW     = ADDR_BITS + COMP_W;
    localparam int RAM_DEPTH  = 2 ** RAM_AW;
    localparam int DIV_STEPS  = (IDX_BITS + FRAC_BITS + 1) / 2;
    localparam int DIV_IDX_W  = 2 * DIV_STEPS - FRAC_BITS;
    localparam int DIFF_W     = VALUE_BITS + 1;
    localparam int PROD_W     = VALUE_BITS + FRAC_BITS + 3;
    localparam logic [FRAC_BITS:0]  FRAC_ONE   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [PROD_W-1:0]   ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [2:0]          LAST_CORNER = 3'd7;
    localparam logic [2:0]          LAST_STEP   = 3'd6;

    // Configuration registers; counts and cell size are kept already clamped.
    logic signed [POS_W-1:0] r_origin [3];
    logic [CNT_W-1:0]        r_count  [3];
    logic [CELL_W-1:0]       r_cell;
    logic [SPAN_W-1:0]       r_span   [3];

    t_state r_state;
    t_state n_state;

    logic [COMP_W-1:0]        r_comp;
    logic signed [DIST_W-1:0] r_dist  [3];
    logic [IDX_BITS-1:0]      r_idx   [3];
    logic [FRAC_BITS:0]       r_frac  [3];
    logic [T1_W-1:0]          r_t1;
    logic [SX_W-1:0]          r_sx;
    logic [FLAT_W-1:0]        r_base;
    logic [2:0]               r_cnt;
    logic                     r_cap_en;
    logic [2:0]               r_cap_idx;
    logic signed [VALUE_BITS-1:0] r_corner [8];
    logic signed [VALUE_BITS-1:0] r_mid    [6];
    logic [2:0]               r_step;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [VALUE_BITS-1:0] r_a;
    logic                     r_out_valid;
    t_out_item                r_out;

    // Transaction decode.
    logic accept;
    logic load_we;
    logic query;
    logic [CNT_W-1:0] cfg_count;

    // Per axis location.
    logic signed [POS_W-1:0]  pos_in    [3];
    logic signed [DIST_W-1:0] dist_in   [3];
    logic [DIV_IDX_W-1:0]     div_index [3];
    logic [FRAC_BITS-1:0]     div_frac  [3];
    logic [2:0]               div_done_v;
    logic                     div_done;
    logic [2:0]               axis_in;
    logic                     in_grid;
    logic                     proceed;
    logic [CNT_W-1:0]         axis_last [3];
    logic [IDX_BITS-1:0]      loc_idx   [3];
    logic [FRAC_BITS:0]       loc_frac  [3];

    // Memory access.
    logic [FLAT_W-1:0]     corner_addr;
    logic                  ram_we;
    logic [RAM_AW-1:0]     ram_addr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic [VALUE_BITS-1:0] ram_rdata;

    // Shared blend unit.
    logic signed [VALUE_BITS-1:0] op_a;
    logic signed [VALUE_BITS-1:0] op_b;
    logic [FRAC_BITS:0]           op_f;
    logic signed [DIFF_W-1:0]     bl_diff;
    logic signed [PROD_W-1:0]     bl_prod;
    logic signed [PROD_W-1:0]     bl_sum;
    logic signed [VALUE_BITS-1:0] bl_res;

    // Result launch.
    logic                  out_fire;
    logic [FIELD_W-1:0]    out_value;
    logic                  out_inside;

    assign o_busy  = (r_state != S_IDLE);
    assign accept  = i_start && !o_busy;
    assign load_we = accept && (i_item.command == CMD_LOAD) && (i_item.component != COMP_NONE);
    assign query   = accept && (i_item.command == CMD_QUERY);

    // Grid point counts below two behave as two.
    assign cfg_count = (i_cfg_data[CNT_W-1:0] < CNT_W'(2)) ? CNT_W'(2)
                                                           : i_cfg_data[CNT_W-1:0];

    assign pos_in[0] = i_item.pos_x;
    assign pos_in[1] = i_item.pos_y;
    assign pos_in[2] = i_item.pos_z;

    // Offsets from the grid origin and the per-axis location of the cell.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            dist_in[a]   = DIST_W'(pos_in[a]) - DIST_W'(r_origin[a]);
            axis_in[a]   = !r_dist[a][DIST_W-1] && (r_dist[a][SPAN_W-1:0] <= r_span[a]);
            axis_last[a] = r_count[a] - CNT_W'(1);
            // A position on the last grid plane falls in the last cell with fraction one.
            if (CNT_W'(div_index[a]) >= axis_last[a]) begin
                loc_idx[a]  = IDX_BITS'(r_count[a] - CNT_W'(2));
                loc_frac[a] = FRAC_ONE;
            end else begin
                loc_idx[a]  = IDX_BITS'(div_index[a]);
                loc_frac[a] = {1'b0, div_frac[a]};
            end
        end
        in_grid = &axis_in;
        proceed = in_grid && (r_comp != COMP_NONE);
    end

    assign div_done = &div_done_v;

    for (genvar g = 0; g < 3; g++) begin : g_div
        tgfl_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (query),
            .i_dist  (dist_in[g][POS_W-1:0]),
            .i_cell  (r_cell),
            .o_done  (div_done_v[g]),
            .o_index (div_index[g]),
            .o_frac  (div_frac[g])
        );
    end

    // Corner r_cnt = {dz, dy, dx}: x steps by ny*nz, y by nz, z by one.
    always_comb begin
        corner_addr = r_base
                    + (r_cnt[0] ? FLAT_W'(r_sx) : '0)
                    + (r_cnt[1] ? FLAT_W'(r_count[2]) : '0)
                    + FLAT_W'(r_cnt[2]);
    end

    assign ram_we    = load_we;
    assign ram_wdata = VALUE_BITS'(i_item.load_value);
    assign ram_addr  = load_we ? {i_item.component, ADDR_BITS'(i_item.load_address)}
                               : {r_comp, corner_addr[ADDR_BITS-1:0]};

    // The component tables share one memory, selected by the upper address bits.
    tgfl_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Blends run x first over the four corner pairs, then y, then z.
    always_comb begin
        case (r_step)
            3'd0: begin
                op_a = r_corner[0];
                op_b = r_corner[1];
                op_f = r_frac[0];
            end
            3'd1: begin
                op_a = r_corner[2];
                op_b = r_corner[3];
                op_f = r_frac[0];
            end
            3'd2: begin
                op_a = r_corner[4];
                op_b = r_corner[5];
                op_f = r_frac[0];
            end
            3'd3: begin
                op_a = r_corner[6];
                op_b = r_corner[7];
                op_f = r_frac[0];
            end
            3'd4: begin
                op_a = r_mid[0];
                op_b = r_mid[1];
                op_f = r_frac[1];
            end
            3'd5: begin
                op_a = r_mid[2];
                op_b = r_mid[3];
                op_f = r_frac[1];
            end
            3'd6: begin
                op_a = r_mid[4];
                op_b = r_mid[5];
                op_f = r_frac[2];
            end
            default: begin
                op_a = '0;
                op_b = '0;
                op_f = '0;
            end
        endcase
        bl_diff = DIFF_W'(op_b) - DIFF_W'(op_a);
        bl_prod = PROD_W'(bl_diff) * PROD_W'($signed({1'b0, op_f}));
        // An arithmetic shift floors; the result stays between the two endpoints.
        bl_sum  = (r_prod + $signed(ROUND_HALF)) >>> FRAC_BITS;
        bl_res  = VALUE_BITS'(bl_sum + PROD_W'(r_a));
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (query) n_state = S_DIV;
            S_DIV:       if (div_done) n_state = S_LOCATE;
            S_LOCATE:    n_state = proceed ? S_ADDR_A : S_IDLE;
            S_ADDR_A:    n_state = S_ADDR_B;
            S_ADDR_B:    n_state = S_READ;
            S_READ:      if (r_cnt == LAST_CORNER) n_state = S_READ_LAST;
            S_READ_LAST: n_state = S_MUL;
            S_MUL:       n_state = S_ADD;
            S_ADD:       n_state = (r_step == LAST_STEP) ? S_IDLE : S_MUL;
            default:     n_state = S_IDLE;
        endcase
    end

    // Result launch: early zero for an outside position or component three, else the last blend.
    always_comb begin
        out_fire   = 1'b0;
        out_value  = '0;
        out_inside = 1'b0;
        unique case (r_state)
            S_LOCATE: begin
                if (!proceed) begin
                    out_fire   = 1'b1;
                    out_inside = in_grid;
                end
            end
            S_ADD: begin
                if (r_step == LAST_STEP) begin
                    out_fire   = 1'b1;
                    out_value  = FIELD_W'($unsigned(bl_res));
                    out_inside = 1'b1;
                end
            end
            default: begin
                out_fire = 1'b0;
            end
        endcase
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cap_en    <= 1'b0;
            r_cnt       <= '0;
            r_step      <= '0;
            r_origin[0] <= '0;
            r_origin[1] <= '0;
            r_origin[2] <= '0;
            r_count[0]  <= CNT_W'(2);
            r_count[1]  <= CNT_W'(2);
            r_count[2]  <= CNT_W'(2);
            r_cell      <= CELL_W'(800);
        end else begin
            r_state     <= n_state;
            r_out_valid <= out_fire;
            r_cap_en    <= (r_state == S_READ);
            if (r_state == S_ADDR_B) begin
                r_cnt <= '0;
            end else if (r_state == S_READ) begin
                r_cnt <= r_cnt + 3'd1;
            end
            if (r_state == S_READ_LAST) begin
                r_step <= '0;
            end else if (r_state == S_ADD) begin
                r_step <= r_step + 3'd1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_ORIGIN_X: r_origin[0] <= i_cfg_data[POS_W-1:0];
                    REG_ORIGIN_Y: r_origin[1] <= i_cfg_data[POS_W-1:0];
                    REG_ORIGIN_Z: r_origin[2] <= i_cfg_data[POS_W-1:0];
                    REG_COUNT_X:  r_count[0]  <= cfg_count;
                    REG_COUNT_Y:  r_count[1]  <= cfg_count;
                    REG_COUNT_Z:  r_count[2]  <= cfg_count;
                    REG_CELL_SIZE: begin
                        r_cell <= (i_cfg_data[CELL_W-1:0] == '0) ? CELL_W'(1)
                                                                 : i_cfg_data[CELL_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_span[a] <= SPAN_W'(IDX_BITS'(r_count[a] - CNT_W'(1))) * SPAN_W'(r_cell);
        end
        if (query) begin
            r_comp <= i_item.component;
            for (int a = 0; a < 3; a++) begin
                r_dist[a] <= dist_in[a];
            end
        end
        if (r_state == S_LOCATE) begin
            for (int a = 0; a < 3; a++) begin
                r_idx[a]  <= loc_idx[a];
                r_frac[a] <= loc_frac[a];
            end
        end
        if (r_state == S_ADDR_A) begin
            r_t1 <= T1_W'(r_idx[0]) * T1_W'(r_count[1]) + T1_W'(r_idx[1]);
            r_sx <= SX_W'(r_count[1]) * SX_W'(r_count[2]);
        end
        if (r_state == S_ADDR_B) begin
            r_base <= FLAT_W'(r_t1) * FLAT_W'(r_count[2]) + FLAT_W'(r_idx[2]);
        end
        r_cap_idx <= r_cnt;
        if (r_cap_en) begin
            r_corner[r_cap_idx] <= ram_rdata;
        end
        if (r_state == S_MUL) begin
            r_prod <= bl_prod;
            r_a    <= op_a;
        end
        if (r_state == S_ADD && r_step != LAST_STEP) begin
            r_mid[r_step] <= bl_res;
        end
        if (out_fire) begin
            r_out.field_value <= out_value;
            r_out.inside_res  <= out_inside;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // A result only follows the last blend or the early exit after location.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == S_ADD || $past(r_state) == S_LOCATE))
        else $error("result strobe without a finished query");

    // Positions outside the grid return zero.
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.inside_res |-> o_result.field_value == '0)
        else $error("nonzero field for an outside position");

    // Location only uses quotients the dividers have finished.
    a_div_before_locate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LOCATE |-> $past(div_done))
        else $error("cell located before division finished");

    // When a result shows, the block already takes the next transaction.
    a_free_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("block still busy while presenting a result");

endmodule
